/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they expand to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CLPW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CLPW_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define CLPW_ASSERT(label, clk, rst, prop, msg)
`define CLPW_NEVER(label, clk, rst, expr, msg)
`endif
`endif

/* rtl/clpw_pkg.sv */
// ---------------------------------------------------------------------------
// clpw_pkg
// Types, codes, microcode fields and the Cyrillic translation for the writer.
// ---------------------------------------------------------------------------
`default_nettype none
package clpw_pkg;

   localparam int unsigned TICK_W   = 16;
   localparam int unsigned HIGH_W   = 18;
   localparam int unsigned STEP_W   = 3;
   localparam int unsigned BIT_W    = 3;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [1:0] CMD_INSTR  = 2'd0;
   localparam logic [1:0] CMD_DATA   = 2'd1;
   localparam logic [1:0] CMD_CYR    = 2'd2;
   localparam logic [1:0] CMD_NIBBLE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_GAP  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STROBE_GAP = 3'd4;

   localparam logic [TICK_W-1:0] SHORT_LOW_RESET  = 16'd1;
   localparam logic [TICK_W-1:0] LONG_LOW_RESET   = 16'd5;
   localparam logic [TICK_W-1:0] RECOVERY_RESET   = 16'd5;
   localparam logic [TICK_W-1:0] FRAME_GAP_RESET  = 16'd150;
   localparam logic [TICK_W-1:0] STROBE_GAP_RESET = 16'd50;

   localparam logic [STEP_W-1:0] STEP_HI_E     = 3'd0;
   localparam logic [STEP_W-1:0] STEP_HI_ED    = 3'd1;
   localparam logic [STEP_W-1:0] STEP_HI_D     = 3'd2;
   localparam logic [STEP_W-1:0] STEP_LO_E     = 3'd3;
   localparam logic [STEP_W-1:0] STEP_LO_ED    = 3'd4;
   localparam logic [STEP_W-1:0] STEP_LO_D     = 3'd5;

   localparam logic [BIT_W-1:0] BIT_LAST = 3'd7;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] value;
   } req_word_type;

   typedef struct packed {
      logic              bit_sent;
      logic [TICK_W-1:0] low_time;
      logic [HIGH_W-1:0] high_time;
      logic              last;
   } rsp_word_type;

   typedef struct packed {
      logic use_e;
      logic use_d;
      logic nib_hi;
      logic third;
      logic done;
   } ucode_word_type;

   typedef struct packed {
      logic                busy;
      logic [STEP_W-1:0]   step;
      logic [BIT_W-1:0]    bit_idx;
      ucode_word_type      ctl;
   } seq_status_type;

   localparam logic [7:0] CYR_UPPER [32] = '{
      8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'h33,
      8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
      8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
      8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1
   };
   localparam logic [7:0] CYR_LOWER [32] = '{
      8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
      8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
      8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
      8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
   };

   function automatic logic [7:0] translate(input logic [7:0] c);
      logic [7:0] r;
      if (c[7:5] == 3'b111) begin
         r = CYR_LOWER[c[4:0]];
      end else if (c[7:5] == 3'b110) begin
         r = CYR_UPPER[c[4:0]];
      end else if (c == 8'hA8) begin
         r = 8'hA2;
      end else if (c == 8'hB8) begin
         r = 8'hB5;
      end else begin
         r = c;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/clpw_ucode_rom.sv */
// ---------------------------------------------------------------------------
// clpw_ucode_rom
// Control store: one control word for each frame of the write program.
// ---------------------------------------------------------------------------
`default_nettype none
module clpw_ucode_rom (
   input  wire logic [clpw_pkg::STEP_W-1:0] step,
   output clpw_pkg::ucode_word_type         ctl
);

   always_comb begin
      ctl = '0;
      case (step)
         clpw_pkg::STEP_HI_E:  ctl = '{use_e: 1'b1, use_d: 1'b0, nib_hi: 1'b1,
                                     third: 1'b0, done: 1'b0};
         clpw_pkg::STEP_HI_ED: ctl = '{use_e: 1'b1, use_d: 1'b1, nib_hi: 1'b1,
                                     third: 1'b0, done: 1'b0};
         clpw_pkg::STEP_HI_D:  ctl = '{use_e: 1'b0, use_d: 1'b1, nib_hi: 1'b1,
                                     third: 1'b1, done: 1'b0};
         clpw_pkg::STEP_LO_E:  ctl = '{use_e: 1'b1, use_d: 1'b0, nib_hi: 1'b0,
                                     third: 1'b0, done: 1'b0};
         clpw_pkg::STEP_LO_ED: ctl = '{use_e: 1'b1, use_d: 1'b1, nib_hi: 1'b0,
                                     third: 1'b0, done: 1'b0};
         clpw_pkg::STEP_LO_D:  ctl = '{use_e: 1'b0, use_d: 1'b1, nib_hi: 1'b0,
                                     third: 1'b1, done: 1'b1};
         default:              ctl = '{use_e: 1'b0, use_d: 1'b0, nib_hi: 1'b0,
                                     third: 1'b0, done: 1'b1};
      endcase
   end

endmodule
`default_nettype wire

/* rtl/clpw_sequencer.sv */
// ---------------------------------------------------------------------------
// clpw_sequencer
// Step counter and bit counter that walk the control store, eight pulses a step.
// ---------------------------------------------------------------------------
`default_nettype none
module clpw_sequencer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [clpw_pkg::STEP_W-1:0] start_step,
   input  wire logic                        fire,
   output clpw_pkg::seq_status_type         status
);

   logic                        busy_ff, busy_in;
   logic [clpw_pkg::STEP_W-1:0] step_ff, step_in;
   logic [clpw_pkg::BIT_W-1:0]  bit_ff, bit_in;
   clpw_pkg::ucode_word_type    ctl;

   clpw_ucode_rom u_rom (
      .step (step_ff),
      .ctl  (ctl)
   );

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = start_step;
         bit_in  = '0;
      end else if (fire) begin
         bit_in = bit_ff + 1'b1;
         if (bit_ff == clpw_pkg::BIT_LAST) begin
            if (ctl.done) begin
               busy_in = 1'b0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         bit_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         bit_ff  <= bit_in;
      end
   end

   assign status = '{busy: busy_ff, step: step_ff, bit_idx: bit_ff, ctl: ctl};

endmodule
`default_nettype wire

/* rtl/char_lcd_one_wire_pulse_writer.sv */
// ---------------------------------------------------------------------------
// char_lcd_one_wire_pulse_writer
// Turns one LCD write into shift register frames sent as pulse-width bits.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake           Word
//  req      in         req_valid/req_stall cmd, value
//  rsp      out        rsp_valid/rsp_stall bit_sent, low_time, high_time, last
//  csr      in         csr_we              csr_index, csr_wdata
//
// One pulse word leaves per cycle while a write is in progress and the result side
// does not stall. A byte write sends 48 pulses and a bare nibble 24; the input is
// stalled while the sequencer is busy with them.
// The next write is taken once the last pulse has entered the output register.
// Reset is synchronous and restores the timing registers to their defaults.
// A stall on the result side while a pulse word is waiting there holds the sequencer where it is.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module char_lcd_one_wire_pulse_writer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire clpw_pkg::req_word_type         req_word,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      clpw_pkg::rsp_word_type         rsp_word,
   input  wire logic                           csr_we,
   input  wire logic [clpw_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [clpw_pkg::TICK_W-1:0]    csr_wdata
);

   logic [clpw_pkg::TICK_W-1:0] short_low_ff, long_low_ff, recovery_ff;
   logic [clpw_pkg::TICK_W-1:0] frame_gap_ff, strobe_gap_ff;
   logic                        rs_ff, rs_in;
   logic [7:0]                  code_ff, code_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   clpw_pkg::rsp_word_type      rsp_word_ff, rsp_word_in;

   logic                        start, fire;
   logic [clpw_pkg::STEP_W-1:0] start_step;
   clpw_pkg::seq_status_type    status;
   logic [3:0]                  nib;
   logic [7:0]                  frame;
   logic                        pulse_bit;
   logic [clpw_pkg::HIGH_W-1:0] gap;

   assign req_stall = status.busy;
   assign start     = req_valid && !status.busy;
   assign fire      = status.busy && (!rsp_valid_ff || !rsp_stall);
   assign start_step = (req_word.cmd == clpw_pkg::CMD_NIBBLE) ? clpw_pkg::STEP_LO_E
                                                              : clpw_pkg::STEP_HI_E;

   clpw_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_step (start_step),
      .fire       (fire),
      .status     (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         short_low_ff  <= clpw_pkg::SHORT_LOW_RESET;
         long_low_ff   <= clpw_pkg::LONG_LOW_RESET;
         recovery_ff   <= clpw_pkg::RECOVERY_RESET;
         frame_gap_ff  <= clpw_pkg::FRAME_GAP_RESET;
         strobe_gap_ff <= clpw_pkg::STROBE_GAP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            clpw_pkg::CSR_SHORT_LOW:  short_low_ff  <= csr_wdata;
            clpw_pkg::CSR_LONG_LOW:   long_low_ff   <= csr_wdata;
            clpw_pkg::CSR_RECOVERY:   recovery_ff   <= csr_wdata;
            clpw_pkg::CSR_FRAME_GAP:  frame_gap_ff  <= csr_wdata;
            clpw_pkg::CSR_STROBE_GAP: strobe_gap_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      rs_in   = rs_ff;
      code_in = code_ff;
      if (start) begin
         case (req_word.cmd)
            clpw_pkg::CMD_INSTR: begin
               rs_in   = 1'b0;
               code_in = req_word.value;
            end
            clpw_pkg::CMD_DATA: begin
               rs_in   = 1'b1;
               code_in = req_word.value;
            end
            clpw_pkg::CMD_CYR: begin
               rs_in   = 1'b1;
               code_in = clpw_pkg::translate(req_word.value);
            end
            clpw_pkg::CMD_NIBBLE: begin
               code_in = {4'b0000, req_word.value[3:0]};
            end
            default: ;
         endcase
      end
   end

   assign nib       = status.ctl.nib_hi ? code_ff[7:4] : code_ff[3:0];
   assign frame     = {2'b00, rs_ff, status.ctl.use_e, (status.ctl.use_d ? nib : 4'b0000)};
   assign pulse_bit = frame[status.bit_idx];

   always_comb begin
      gap = '0;
      if (status.bit_idx == clpw_pkg::BIT_LAST) begin
         gap = {2'b00, frame_gap_ff} +
               (status.ctl.third ? {2'b00, strobe_gap_ff} : '0);
      end
      rsp_word_in.bit_sent  = pulse_bit;
      rsp_word_in.low_time  = pulse_bit ? short_low_ff : long_low_ff;
      rsp_word_in.high_time = {2'b00, recovery_ff} + gap;
      rsp_word_in.last      = status.ctl.done && (status.bit_idx == clpw_pkg::BIT_LAST);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_ff        <= 1'b0;
         code_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rs_ff        <= rs_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `CLPW_ASSERT(a_last_ends_write, clock, reset, (fire && rsp_word_in.last) |=> !status.busy, "sequencer still busy after the last pulse")
   `CLPW_ASSERT(a_start_clears_bits, clock, reset, start |=> (status.busy && status.bit_idx == '0), "write did not start at the first bit")
   `CLPW_NEVER(a_step_in_program, clock, reset, status.busy && (status.step > clpw_pkg::STEP_LO_D), "step counter left the program")

endmodule
`default_nettype wire

/* dv/char_lcd_one_wire_pulse_writer_test.sv */
// ---------------------------------------------------------------------------
// char_lcd_one_wire_pulse_writer_test
// Self-checking testbench for the one-wire pulse writer. A queue of LCD
// writes feeds a clocked driver that sends them in bursts with random gaps.
// The result side stalls on its own pattern. Every accepted write is expanded
// into its expected line pulses, and each pulse word that leaves the block is
// compared field by field with the oldest expected pulse. The run goes through
// the reset timing, all-zero and all-ones timing, the smallest legal timing
// and several random settings.
// ---------------------------------------------------------------------------
module char_lcd_one_wire_pulse_writer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CSR_IDX_W    = clpw_pkg::CSR_IDX_W;
   localparam int unsigned TICK_W       = clpw_pkg::TICK_W;
   localparam int unsigned HIGH_W       = clpw_pkg::HIGH_W;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_INDEX = 3'd7;

   localparam logic [7:0] UPPER_CODES [32] = '{
      8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'h33,
      8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
      8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
      8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1
   };
   localparam logic [7:0] LOWER_CODES [32] = '{
      8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
      8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
      8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
      8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
   };

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   clpw_pkg::req_word_type req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   clpw_pkg::rsp_word_type rsp_word;
   logic                   csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [TICK_W-1:0]      csr_wdata = '0;

   logic [TICK_W-1:0] short_ticks    = clpw_pkg::SHORT_LOW_RESET;
   logic [TICK_W-1:0] long_ticks     = clpw_pkg::LONG_LOW_RESET;
   logic [TICK_W-1:0] recovery_ticks = clpw_pkg::RECOVERY_RESET;
   logic [TICK_W-1:0] frame_ticks    = clpw_pkg::FRAME_GAP_RESET;
   logic [TICK_W-1:0] strobe_ticks   = clpw_pkg::STROBE_GAP_RESET;
   logic              rs_now         = 1'b0;

   clpw_pkg::req_word_type write_queue [$];
   clpw_pkg::rsp_word_type pulse_queue [$];
   logic           word_taken   = 1'b0;
   int unsigned    burst_left   = 1;
   int unsigned    gap_left     = 0;
   stall_mode_type stall_mode   = STALL_NONE;
   int unsigned    mode_left    = 0;
   int unsigned    stall_period = 4;
   int unsigned    cycle_count  = 0;
   int unsigned    fault_count  = 0;
   int unsigned    words_sent   = 0;
   int unsigned    pulses_seen  = 0;
   int unsigned    settings_run = 1;

   char_lcd_one_wire_pulse_writer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic logic [7:0] lcd_code(input logic [7:0] c);
      if (c >= 8'hE0) return LOWER_CODES[c[4:0]];
      if (c >= 8'hC0) return UPPER_CODES[c[4:0]];
      if (c == 8'hA8) return 8'hA2;
      if (c == 8'hB8) return 8'hB5;
      return c;
   endfunction

   function automatic void queue_pulses(input logic [1:0] cmd, input logic [7:0] value);
      logic [3:0]             nibbles [2];
      int                     count;
      logic [7:0]             code;
      logic [7:0]             frame;
      clpw_pkg::rsp_word_type p;
      if (cmd == clpw_pkg::CMD_NIBBLE) begin
         nibbles[0] = value[3:0];
         count = 1;
      end else begin
         rs_now = (cmd != clpw_pkg::CMD_INSTR);
         code = (cmd == clpw_pkg::CMD_CYR) ? lcd_code(value) : value;
         nibbles[0] = code[7:4];
         nibbles[1] = code[3:0];
         count = 2;
      end
      for (int n = 0; n < count; n++) begin
         for (int f = 0; f < 3; f++) begin
            frame = {2'b00, rs_now, (f < 2), ((f > 0) ? nibbles[n] : 4'h0)};
            for (int b = 0; b < 8; b++) begin
               p.bit_sent  = frame[b];
               p.low_time  = frame[b] ? short_ticks : long_ticks;
               p.high_time = HIGH_W'(recovery_ticks);
               if (b == 7) begin
                  p.high_time += HIGH_W'(frame_ticks);
                  if (f == 2) p.high_time += HIGH_W'(strobe_ticks);
               end
               p.last = (n == count - 1) && (f == 2) && (b == 7);
               pulse_queue.push_back(p);
            end
         end
      end
   endfunction

   function automatic clpw_pkg::req_word_type random_write();
      clpw_pkg::req_word_type w;
      int                     pick;
      pick = $urandom_range(0, 9);
      w.value = 8'($urandom);
      if (pick < 3) begin
         w.cmd = clpw_pkg::CMD_INSTR;
      end else if (pick < 5) begin
         w.cmd = clpw_pkg::CMD_DATA;
      end else if (pick < 8) begin
         w.cmd = clpw_pkg::CMD_CYR;
         case ($urandom_range(0, 3))
            0, 1: begin
               w.value = {2'b11, w.value[5:0]};
            end
            2: begin
               w.value = ($urandom_range(0, 1) != 0) ? 8'hA8 : 8'hB8;
            end
            default: begin
            end
         endcase
      end else begin
         w.cmd = clpw_pkg::CMD_NIBBLE;
      end
      return w;
   endfunction

   task automatic add_write(input logic [1:0] cmd, input logic [7:0] value);
      clpw_pkg::req_word_type w;
      w.cmd = cmd;
      w.value = value;
      write_queue.push_back(w);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [TICK_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         clpw_pkg::CSR_SHORT_LOW:  short_ticks    = data;
         clpw_pkg::CSR_LONG_LOW:   long_ticks     = data;
         clpw_pkg::CSR_RECOVERY:   recovery_ticks = data;
         clpw_pkg::CSR_FRAME_GAP:  frame_ticks    = data;
         clpw_pkg::CSR_STROBE_GAP: strobe_ticks   = data;
         default: begin
         end
      endcase
   endtask

   task automatic apply_timing(input logic [TICK_W-1:0] s, input logic [TICK_W-1:0] l,
                               input logic [TICK_W-1:0] r, input logic [TICK_W-1:0] f,
                               input logic [TICK_W-1:0] g);
      write_csr(clpw_pkg::CSR_SHORT_LOW, s);
      write_csr(clpw_pkg::CSR_LONG_LOW, l);
      write_csr(clpw_pkg::CSR_RECOVERY, r);
      write_csr(clpw_pkg::CSR_FRAME_GAP, f);
      write_csr(clpw_pkg::CSR_STROBE_GAP, g);
      for (int i = clpw_pkg::CSR_STROBE_GAP + 1; i <= CSR_LAST_INDEX; i++) begin
         write_csr(CSR_IDX_W'(i), TICK_W'($urandom));
      end
      @(negedge clock);
      csr_we <= 1'b0;
      settings_run++;
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (write_queue.size() != 0 || req_valid || pulse_queue.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic report_fault(input string what, input clpw_pkg::rsp_word_type want,
                               input clpw_pkg::rsp_word_type got);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) begin
         $display("%s at pulse %0d: expected bit %0d low %0d high %0d last %0d,",
                  what, pulses_seen, want.bit_sent, want.low_time, want.high_time,
                  want.last);
         $display("   got bit %0d low %0d high %0d last %0d",
                  got.bit_sent, got.low_time, got.high_time, got.last);
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !word_taken) begin
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (write_queue.size() != 0) begin
         req_valid <= 1'b1;
         req_word  <= write_queue.pop_front();
         if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 6);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode   <= stall_mode_type'($urandom_range(0, 3));
         mode_left    <= $urandom_range(20, 400);
         stall_period <= $urandom_range(2, 9);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 4) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ((cycle_count % stall_period) < (stall_period / 2));
      endcase
   end

   always @(posedge clock) begin
      clpw_pkg::rsp_word_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("char_lcd_one_wire_pulse_writer regression: fail");
         $finish;
      end else if (reset) begin
         word_taken <= 1'b0;
      end else begin
         word_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            queue_pulses(req_word.cmd, req_word.value);
            words_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pulse_queue.size() == 0) begin
               report_fault("Unexpected word", '0, rsp_word);
            end else begin
               want = pulse_queue.pop_front();
               if (rsp_word.bit_sent !== want.bit_sent ||
                   rsp_word.low_time !== want.low_time ||
                   rsp_word.high_time !== want.high_time ||
                   rsp_word.last !== want.last) begin
                  report_fault("Mismatch", want, rsp_word);
               end
            end
            pulses_seen++;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A bare nibble straight after reset uses the reset RS of zero.
      add_write(clpw_pkg::CMD_NIBBLE, 8'hF5);
      add_write(clpw_pkg::CMD_INSTR, 8'h00);
      add_write(clpw_pkg::CMD_INSTR, 8'hFF);
      add_write(clpw_pkg::CMD_NIBBLE, 8'hF0);
      add_write(clpw_pkg::CMD_NIBBLE, 8'h0F);
      add_write(clpw_pkg::CMD_DATA, 8'h00);
      add_write(clpw_pkg::CMD_DATA, 8'hFF);
      add_write(clpw_pkg::CMD_NIBBLE, 8'hFF);
      add_write(clpw_pkg::CMD_NIBBLE, 8'h00);
      add_write(clpw_pkg::CMD_DATA, 8'hA5);
      add_write(clpw_pkg::CMD_DATA, 8'h5A);
      add_write(clpw_pkg::CMD_CYR, 8'hC0);
      add_write(clpw_pkg::CMD_CYR, 8'hDF);
      add_write(clpw_pkg::CMD_CYR, 8'hE0);
      add_write(clpw_pkg::CMD_CYR, 8'hFF);
      add_write(clpw_pkg::CMD_CYR, 8'hA8);
      add_write(clpw_pkg::CMD_CYR, 8'hB8);
      add_write(clpw_pkg::CMD_CYR, 8'hBF);
      add_write(clpw_pkg::CMD_CYR, 8'h41);
      add_write(clpw_pkg::CMD_CYR, 8'hA7);
      add_write(clpw_pkg::CMD_INSTR, 8'hC5);
      add_write(clpw_pkg::CMD_NIBBLE, 8'hA3);
      for (int i = 0; i < 60; i++) write_queue.push_back(random_write());
      wait_idle();

      for (int phase = 1; phase <= 6; phase++) begin
         case (phase)
            1: apply_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
            2: apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: apply_timing(16'd1, 16'd1, 16'd1, 16'd0, 16'd0);
            4: apply_timing(TICK_W'($urandom_range(1, 65535)),
                            TICK_W'($urandom_range(1, 65535)),
                            TICK_W'($urandom_range(1, 65535)),
                            TICK_W'($urandom_range(0, 65535)),
                            TICK_W'($urandom_range(0, 65535)));
            5: apply_timing(TICK_W'($urandom_range(1, 8)), TICK_W'($urandom_range(1, 8)),
                            TICK_W'($urandom_range(1, 8)), TICK_W'($urandom_range(0, 20)),
                            TICK_W'($urandom_range(0, 20)));
            default: apply_timing(TICK_W'($urandom_range(1, 3)),
                                  TICK_W'($urandom_range(200, 65535)),
                                  TICK_W'($urandom), TICK_W'($urandom), TICK_W'($urandom));
         endcase
         for (int i = 0; i < 70; i++) write_queue.push_back(random_write());
         wait_idle();
      end

      repeat (20) @(posedge clock);
      $display("Summary: %0d LCD writes under %0d timing settings, %0d pulse words checked.",
               words_sent, settings_run, pulses_seen);
      $display("Summary: %0d mismatched or unexpected words, %0d pulses still outstanding.",
               fault_count, pulse_queue.size());
      if (fault_count == 0 && pulse_queue.size() == 0) begin
         $display("char_lcd_one_wire_pulse_writer regression: pass");
      end else begin
         $display("char_lcd_one_wire_pulse_writer regression: fail");
      end
      $finish;
   end

endmodule
